// ===== src/mts_pkg.sv =====
// shared constants and types for the min-tracking stack
`default_nettype none
package mts_pkg;

  // value and stored entry widths (entry is two's complement, one bit wider)
  localparam int unsigned VALUE_BITS = 16;
  localparam int unsigned ENTRY_BITS = VALUE_BITS + 1;
  localparam int unsigned OP_BITS    = 2;
  localparam int unsigned ST_BITS    = 2;

  // operation codes
  localparam logic [OP_BITS-1:0] OP_PUSH = 2'd0;
  localparam logic [OP_BITS-1:0] OP_POP  = 2'd1;
  localparam logic [OP_BITS-1:0] OP_MIN  = 2'd2;

  // status codes
  localparam logic [ST_BITS-1:0] ST_OK    = 2'd0;
  localparam logic [ST_BITS-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_BITS-1:0] ST_FULL  = 2'd2;

  // shift command broadcast to every cell of the chain
  typedef struct packed {
    logic push;
    logic pop;
  } mts_shift_t;

endpackage
`default_nettype wire

// ===== src/mts_cell.sv =====
// one stack cell: holds an entry and shifts it towards either neighbour
`default_nettype none
module mts_cell (
  input  wire logic                           clk_i,
  input  wire mts_pkg::mts_shift_t            shift_i,
  input  wire logic [mts_pkg::ENTRY_BITS-1:0] up_i,    // entry of the cell nearer the top
  input  wire logic [mts_pkg::ENTRY_BITS-1:0] down_i,  // entry of the cell further down
  output logic      [mts_pkg::ENTRY_BITS-1:0] entry_o
);
  import mts_pkg::*;

  logic [ENTRY_BITS-1:0] entry_q;

  // push moves entries away from the top, pop moves them back up
  always_ff @(posedge clk_i) begin
    if (shift_i.push) begin
      entry_q <= up_i;
    end else if (shift_i.pop) begin
      entry_q <= down_i;
    end
  end

  assign entry_o = entry_q;

endmodule
`default_nettype wire

// ===== src/min_tracking_stack_core.sv =====
// top level of the min-tracking stack: control, minimum register and cell chain
//
// A last-in first-out stack of 16-bit unsigned values that also reports its
// current minimum. Each beat on the slave side carries one operation in
// s_axis_tuser_i (push, pop or read minimum) and produces exactly one beat
// on the master side, registered in the cycle after acceptance, with the value in
// m_axis_tdata_o and the status (ok, empty, full) in m_axis_tuser_o. The
// block takes one operation per cycle while s_axis_tready_o is high: the top
// cell of the shift chain and the minimum register are both updated in the
// cycle an operation is accepted, so the next operation sees them at once.
// s_axis_tready_o is low only while the output register holds a beat the
// downstream has not taken. Storage is a chain of STACK_DEPTH cells that
// shift as a whole on every successful push or pop; only the top cell is
// ever read. No clearing pass is needed after reset.
`default_nettype none
module min_tracking_stack_core #(
  parameter int unsigned STACK_DEPTH = 256
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // slave side
  input  wire logic                        s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  wire logic [15:0]                 s_axis_tdata_i,  // [15:0] push_value
  input  wire logic [mts_pkg::OP_BITS-1:0] s_axis_tuser_i,  // [1:0] opcode
  // master side
  output logic                             m_axis_tvalid_o,
  input  wire logic                        m_axis_tready_i,
  output logic      [15:0]                 m_axis_tdata_o,  // [15:0] result_value
  output logic      [mts_pkg::ST_BITS-1:0] m_axis_tuser_o   // [1:0] status
);
  import mts_pkg::*;

  localparam int unsigned CNT_BITS = $clog2(STACK_DEPTH + 1);
  localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(STACK_DEPTH);
  localparam logic [CNT_BITS-1:0] CNT_ONE  = CNT_BITS'(1);

  // state
  logic [CNT_BITS-1:0]   count_q, count_d;
  logic [VALUE_BITS-1:0] min_q, min_d;
  logic                  out_valid_q, out_valid_d;
  logic [VALUE_BITS-1:0] res_q, res_d;
  logic [ST_BITS-1:0]    st_q, st_d;

  // cell chain
  logic [ENTRY_BITS-1:0] cell_entry [STACK_DEPTH];
  logic [ENTRY_BITS-1:0] new_entry;
  mts_shift_t            shift;

  // beat handshake
  logic                  s_fire;
  logic [VALUE_BITS-1:0] push_val;
  logic                  empty, full;

  // arithmetic on the top entry and the minimum
  logic [ENTRY_BITS-1:0]        top_entry;
  logic signed [ENTRY_BITS:0]   top_ext, min_ext;
  logic                         top_plain;
  logic [VALUE_BITS-1:0]        restored_min;
  logic                         push_below;
  logic [ENTRY_BITS-1:0]        push_enc;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign push_val        = s_axis_tdata_i[VALUE_BITS-1:0];
  assign empty           = (count_q == '0);
  assign full            = (count_q == CNT_FULL);

  // pop side: an entry not above the minimum was stored encoded
  assign top_entry    = cell_entry[0];
  assign top_ext      = $signed({top_entry[ENTRY_BITS-1], top_entry});
  assign min_ext      = $signed({2'b00, min_q});
  assign top_plain    = (top_ext > min_ext);
  assign restored_min = VALUE_BITS'({min_q, 1'b0} - top_entry);

  // push side: a value below the minimum is stored as twice it less the minimum
  assign push_below = (push_val < min_q);
  assign push_enc   = {push_val, 1'b0} - {1'b0, min_q};
  assign new_entry  = (empty || !push_below) ? {1'b0, push_val} : push_enc;

  // operation decode
  always_comb begin
    count_d     = count_q;
    min_d       = min_q;
    res_d       = res_q;
    st_d        = st_q;
    shift       = '0;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    if (s_fire) begin
      out_valid_d = 1'b1;
      res_d       = '0;
      st_d        = ST_OK;
      unique case (s_axis_tuser_i)
        OP_PUSH: begin
          if (full) begin
            st_d = ST_FULL;
          end else begin
            shift.push = 1'b1;
            count_d    = count_q + CNT_ONE;
            if (empty || push_below) begin
              min_d = push_val;
            end
          end
        end
        OP_POP: begin
          if (empty) begin
            st_d = ST_EMPTY;
          end else begin
            shift.pop = 1'b1;
            count_d   = count_q - CNT_ONE;
            if (top_plain) begin
              res_d = top_entry[VALUE_BITS-1:0];
            end else begin
              res_d = min_q;
              min_d = restored_min;
            end
          end
        end
        OP_MIN: begin
          if (empty) begin
            st_d = ST_EMPTY;
          end else begin
            res_d = min_q;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      min_q       <= '1;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      min_q       <= min_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    st_q  <= st_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = res_q;
  assign m_axis_tuser_o  = st_q;

  // chain of cells, cell 0 is the top of the stack
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [ENTRY_BITS-1:0] up_entry, down_entry;
    if (i == 0) begin : g_top
      assign up_entry = new_entry;
    end else begin : g_mid
      assign up_entry = cell_entry[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bottom
      assign down_entry = '0;
    end else begin : g_inner
      assign down_entry = cell_entry[i+1];
    end
    mts_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (shift),
      .up_i    (up_entry),
      .down_i  (down_entry),
      .entry_o (cell_entry[i])
    );
  end

  // fill level never passes the depth
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_FULL)
    else $error("stack count beyond depth");

  // a successful pop takes exactly one entry away
  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && (s_axis_tuser_i == OP_POP) && !empty
    |=> count_q == $past(count_q) - CNT_ONE)
    else $error("pop did not lower the count");

  // a refused push leaves the count alone and reports full
  a_full_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && (s_axis_tuser_i == OP_PUSH) && full
    |=> (count_q == CNT_FULL) && (m_axis_tuser_o == ST_FULL) && m_axis_tvalid_o)
    else $error("push onto a full stack mishandled");

  // reads on an empty stack report empty with a zero value
  a_empty_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && empty && ((s_axis_tuser_i == OP_POP) || (s_axis_tuser_i == OP_MIN))
    |=> (m_axis_tuser_o == ST_EMPTY) && (m_axis_tdata_o == '0) && (count_q == '0))
    else $error("empty read mishandled");

endmodule
`default_nettype wire
